// ===== hdl/srfc_pkg.sv =====
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types and constants of the save-record checker with FNV-1a 32 hash.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

    localparam logic [15:0] HEADER_BYTES   = 16'd16;
    localparam logic [31:0] FNV_BASIS      = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME      = 32'd16777619;
    localparam int          QUEUE_DEPTH    = 4;
    localparam int          QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_ENCODE   = 2'd0,
        OP_VALIDATE = 2'd1,
        OP_BYTE     = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_INVALID_ARG   = 3'd1,
        ST_VERIFY_FAILED = 3'd2,
        ST_VERSION       = 3'd3,
        ST_CAPACITY      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAGIC    = 2'd0,
        CFG_VERSION  = 2'd1,
        CFG_CAPACITY = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        CMD_FAIL  = 2'd0,
        CMD_START = 2'd1,
        CMD_BYTE  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_opcode      opcode;
        logic [31:0]  magic;
        logic [15:0]  version;
        logic [15:0]  hdr_len;
        logic [31:0]  body_len;
        logic [31:0]  stored_checksum;
        logic [7:0]   data_byte;
    } t_in_item;

    typedef struct packed {
        t_status      status;
        logic [31:0]  magic_out;
        logic [15:0]  version_out;
        logic [15:0]  hdr_len_out;
        logic [31:0]  body_len_out;
        logic [31:0]  hash_result;
    } t_out_item;

    // command passed from the front end to the hash engine
    typedef struct packed {
        t_cmd_kind    kind;
        logic         is_val;
        logic         last;
        t_status      status;
        logic [31:0]  magic;
        logic [15:0]  version;
        logic [31:0]  length;
        logic [31:0]  checksum;
        logic [7:0]   data_byte;
    } t_cmd;

    typedef struct packed {
        logic [31:0]  magic;
        logic [15:0]  version;
        logic [31:0]  capacity;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/save_record_fnv_checker_unit.sv =====
// ----------------------------------------------------------------------------
// save_record_fnv_checker_unit
// Save-record encoder/validator with an FNV-1a 32 payload hash.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock cycle, start items and payload
// bytes alike, as long as the four-entry command queue is not full. The front
// end checks headers and counts bytes in the accepting cycle; the hash engine
// folds one byte per cycle while the output register is free, through a single
// constant multiplier, and writes the result into that register; a result passes
// the command queue and then the output register once the final byte (or a
// failing or empty start) is accepted. Behind a stalled result the queue fills
// after four more commands and ready drops; ignored bytes and reserved opcodes
// take no queue entry. The configuration port is always ready; write it only
// while no record is being processed.
`default_nettype none

module save_record_fnv_checker_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire srfc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output srfc_pkg::t_out_item      o_out_data
);

    srfc_pkg::t_cfg r_cfg;
    logic           w_q_full;
    logic           w_push;
    logic           w_pop;
    logic           w_q_valid;
    srfc_pkg::t_cmd w_cmd_in;
    srfc_pkg::t_cmd w_cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srfc_pkg::CFG_MAGIC:    r_cfg.magic    <= i_cfg_data;
                srfc_pkg::CFG_VERSION:  r_cfg.version  <= i_cfg_data[15:0];
                srfc_pkg::CFG_CAPACITY: r_cfg.capacity <= i_cfg_data;
                default:                r_cfg          <= r_cfg;
            endcase
        end
    end

    srfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    srfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    srfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/srfc_front.sv =====
// ----------------------------------------------------------------------------
// srfc_front
// Accepts transactions, checks start headers (validates against registers),
// tracks the open record and issues commands to the hash engine queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire srfc_pkg::t_cfg    i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire srfc_pkg::t_in_item i_in_data,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output srfc_pkg::t_cmd         o_cmd
);

    logic        r_busy;
    logic [31:0] r_left;
    logic        n_busy;
    logic [31:0] n_left;
    logic        w_accept;
    logic        w_has_cmd;
    srfc_pkg::t_cmd w_cmd;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_busy    = r_busy;
        n_left    = r_left;
        w_has_cmd = 1'b0;
        w_cmd     = '0;
        w_cmd.magic    = i_in_data.magic;
        w_cmd.version  = i_in_data.version;
        w_cmd.length   = i_in_data.body_len;
        w_cmd.checksum = i_in_data.stored_checksum;
        w_cmd.data_byte = i_in_data.data_byte;
        w_cmd.last     = (i_in_data.body_len == 32'd0);
        case (i_in_data.opcode)
            srfc_pkg::OP_ENCODE: begin
                w_has_cmd = 1'b1;
                w_cmd.is_val = 1'b0;
                if (i_in_data.magic == 32'd0 || i_in_data.version == 16'd0) begin
                    w_cmd.kind   = srfc_pkg::CMD_FAIL;
                    w_cmd.status = srfc_pkg::ST_INVALID_ARG;
                    n_busy       = 1'b0;
                end else begin
                    w_cmd.kind   = srfc_pkg::CMD_START;
                    w_cmd.status = srfc_pkg::ST_OK;
                    n_busy       = !w_cmd.last;
                    n_left       = i_in_data.body_len;
                end
            end
            srfc_pkg::OP_VALIDATE: begin
                w_has_cmd    = 1'b1;
                w_cmd.is_val = 1'b1;
                w_cmd.kind   = srfc_pkg::CMD_FAIL;
                n_busy       = 1'b0;
                if (i_cfg.magic == 32'd0 || i_cfg.version == 16'd0) begin
                    w_cmd.status = srfc_pkg::ST_INVALID_ARG;
                end else if (i_in_data.hdr_len != srfc_pkg::HEADER_BYTES ||
                             i_in_data.magic != i_cfg.magic) begin
                    w_cmd.status = srfc_pkg::ST_VERIFY_FAILED;
                end else if (i_in_data.version != i_cfg.version) begin
                    w_cmd.status = srfc_pkg::ST_VERSION;
                end else if (i_in_data.body_len > i_cfg.capacity) begin
                    w_cmd.status = srfc_pkg::ST_CAPACITY;
                end else begin
                    w_cmd.kind   = srfc_pkg::CMD_START;
                    w_cmd.status = srfc_pkg::ST_OK;
                    n_busy       = !w_cmd.last;
                    n_left       = i_in_data.body_len;
                end
            end
            srfc_pkg::OP_BYTE: begin
                // bytes outside an open record are dropped here
                if (r_busy) begin
                    w_has_cmd    = 1'b1;
                    w_cmd.kind   = srfc_pkg::CMD_BYTE;
                    w_cmd.status = srfc_pkg::ST_OK;
                    w_cmd.last   = (r_left == 32'd1);
                    n_left       = r_left - 32'd1;
                    n_busy       = (r_left != 32'd1);
                end
            end
            default: begin
                w_has_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (w_accept) begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

    assign o_push = w_accept && w_has_cmd;
    assign o_cmd  = w_cmd;

endmodule

`default_nettype wire

// ===== hdl/srfc_queue.sv =====
// ----------------------------------------------------------------------------
// srfc_queue
// Small command FIFO between the front end and the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire srfc_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output srfc_pkg::t_cmd      o_cmd
);

    srfc_pkg::t_cmd r_mem [srfc_pkg::QUEUE_DEPTH];
    logic [srfc_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [srfc_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [srfc_pkg::QUEUE_AW:0]   r_count;
    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == (srfc_pkg::QUEUE_AW+1)'(srfc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/srfc_back.sv =====
// ----------------------------------------------------------------------------
// srfc_back
// Hash engine: runs FNV-1a 32 one byte per cycle unless a result is stalled,
// holds the record header and builds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire srfc_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output srfc_pkg::t_out_item  o_out_data
);

    logic        r_is_val;
    logic [31:0] r_hash;
    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [31:0] r_length;
    logic [31:0] r_checksum;
    logic        r_out_valid;
    srfc_pkg::t_out_item r_out;

    logic        w_slot_free;
    logic [31:0] w_mix;
    logic [31:0] w_prod;
    logic        w_emit;
    srfc_pkg::t_out_item w_res;

    function automatic srfc_pkg::t_out_item finish_result(
        input logic        is_val,
        input logic [31:0] magic,
        input logic [15:0] version,
        input logic [31:0] length,
        input logic [31:0] checksum,
        input logic [31:0] hash
    );
        srfc_pkg::t_out_item res;
        res = '0;
        res.hash_result = hash;
        if (!is_val) begin
            res.status       = srfc_pkg::ST_OK;
            res.magic_out    = magic;
            res.version_out  = version;
            res.hdr_len_out  = srfc_pkg::HEADER_BYTES;
            res.body_len_out = length;
        end else if (hash == checksum) begin
            res.status       = srfc_pkg::ST_OK;
            res.body_len_out = length;
        end else begin
            res.status = srfc_pkg::ST_VERIFY_FAILED;
        end
        return res;
    endfunction

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_pop       = i_q_valid && w_slot_free;
    assign w_mix       = r_hash ^ {24'd0, i_cmd.data_byte};
    assign w_prod      = w_mix * srfc_pkg::FNV_PRIME;

    always_comb begin
        w_emit = 1'b0;
        w_res  = '0;
        case (i_cmd.kind)
            srfc_pkg::CMD_FAIL: begin
                w_emit       = 1'b1;
                w_res.status = i_cmd.status;
            end
            srfc_pkg::CMD_START: begin
                // empty payload finishes on the start itself
                w_emit = i_cmd.last;
                w_res  = finish_result(i_cmd.is_val, i_cmd.magic, i_cmd.version,
                                       i_cmd.length, i_cmd.checksum,
                                       srfc_pkg::FNV_BASIS);
            end
            srfc_pkg::CMD_BYTE: begin
                w_emit = i_cmd.last;
                w_res  = finish_result(r_is_val, r_magic, r_version, r_length,
                                       r_checksum, w_prod);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_cmd.kind)
                srfc_pkg::CMD_START: begin
                    r_is_val   <= i_cmd.is_val;
                    r_magic    <= i_cmd.magic;
                    r_version  <= i_cmd.version;
                    r_length   <= i_cmd.length;
                    r_checksum <= i_cmd.checksum;
                    r_hash     <= srfc_pkg::FNV_BASIS;
                end
                srfc_pkg::CMD_BYTE: begin
                    r_hash <= w_prod;
                end
                default: begin
                    r_hash <= r_hash;
                end
            endcase
        end
        if (o_pop && w_emit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hdl/srfc_checker.sv =====
// ----------------------------------------------------------------------------
// srfc_checker
// Port-level checks on the save-record checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire srfc_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= srfc_pkg::ST_CAPACITY)
        else $error("status code out of range");

    a_encode_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == srfc_pkg::ST_OK &&
        o_out_data.magic_out != 32'd0
        |-> o_out_data.hdr_len_out == srfc_pkg::HEADER_BYTES)
        else $error("encoded header has wrong header size");

    a_early_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != srfc_pkg::ST_OK &&
        o_out_data.status != srfc_pkg::ST_VERIFY_FAILED
        |-> o_out_data.hash_result == 32'd0 && o_out_data.body_len_out == 32'd0)
        else $error("early failure carries hash or length");

endmodule

bind save_record_fnv_checker_unit srfc_checker u_srfc_checker (.*);

`default_nettype wire

// ===== tb/sv/save_record_fnv_checker_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// save_record_fnv_checker_unit_test
// Self-checking bench for the save-record checker: streams encode and validate
// records with their payload bytes, mirrors header checks and the FNV-1a hash
// in a bench-side record model, and compares every result field by field.
// ----------------------------------------------------------------------------

module save_record_fnv_checker_unit_test;

    localparam int          RUN_LIMIT    = 2_000_000;
    localparam logic [1:0]  OPC_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        REC_IDLE = 2'd0,
        REC_ENC  = 2'd1,
        REC_VAL  = 2'd2
    } t_rec_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    srfc_pkg::t_in_item  in_data = '0;
    logic                out_ready = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_ready;
    logic                o_out_valid;
    srfc_pkg::t_out_item o_out_data;

    save_record_fnv_checker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // register copies and open-record state of the bench model
    logic [31:0] cfg_magic = '0;
    logic [15:0] cfg_version = '0;
    logic [31:0] cfg_capacity = '0;
    t_rec_mode   rec_mode = REC_IDLE;
    logic [31:0] rec_hash = srfc_pkg::FNV_BASIS;
    logic [31:0] rec_left = '0;
    logic [31:0] rec_magic = '0;
    logic [15:0] rec_version = '0;
    logic [31:0] rec_length = '0;
    logic [31:0] rec_checksum = '0;

    srfc_pkg::t_in_item  pending_items[$];
    srfc_pkg::t_out_item due_results[$];
    srfc_pkg::t_out_item head_result;
    int unsigned idle_pct = 34;
    int unsigned stim_count = 0;
    int unsigned items_taken = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 0;
    int unsigned fail_count = 0;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * srfc_pkg::FNV_PRIME;
    endfunction

    function automatic logic [31:0] body_hash(input logic [7:0] body[$]);
        logic [31:0] h;
        h = srfc_pkg::FNV_BASIS;
        foreach (body[i]) h = fnv_step(h, body[i]);
        return h;
    endfunction

    function automatic srfc_pkg::t_out_item make_result(input srfc_pkg::t_status st,
                                                        input logic [31:0] mg,
                                                        input logic [15:0] ver,
                                                        input logic [15:0] hs,
                                                        input logic [31:0] ps,
                                                        input logic [31:0] h);
        srfc_pkg::t_out_item r;
        r.status       = st;
        r.magic_out    = mg;
        r.version_out  = ver;
        r.hdr_len_out  = hs;
        r.body_len_out = ps;
        r.hash_result  = h;
        return r;
    endfunction

    task automatic close_record();
        if (rec_mode == REC_ENC)
            due_results.push_back(make_result(srfc_pkg::ST_OK, rec_magic, rec_version,
                                              srfc_pkg::HEADER_BYTES, rec_length, rec_hash));
        else if (rec_hash == rec_checksum)
            due_results.push_back(make_result(srfc_pkg::ST_OK, '0, '0, '0, rec_length,
                                              rec_hash));
        else
            due_results.push_back(make_result(srfc_pkg::ST_VERIFY_FAILED, '0, '0, '0, '0,
                                              rec_hash));
        rec_mode = REC_IDLE;
    endtask

    // advance the record model by one accepted transaction
    task automatic fold_record_item(input srfc_pkg::t_in_item it);
        srfc_pkg::t_status verdict;
        case (it.opcode)
            srfc_pkg::OP_ENCODE, srfc_pkg::OP_VALIDATE: begin
                verdict = srfc_pkg::ST_OK;
                if (it.opcode == srfc_pkg::OP_ENCODE) begin
                    if (it.magic == 32'd0 || it.version == 16'd0)
                        verdict = srfc_pkg::ST_INVALID_ARG;
                end else if (cfg_magic == 32'd0 || cfg_version == 16'd0) begin
                    verdict = srfc_pkg::ST_INVALID_ARG;
                end else if (it.hdr_len != srfc_pkg::HEADER_BYTES ||
                             it.magic != cfg_magic) begin
                    verdict = srfc_pkg::ST_VERIFY_FAILED;
                end else if (it.version != cfg_version) begin
                    verdict = srfc_pkg::ST_VERSION;
                end else if (it.body_len > cfg_capacity) begin
                    verdict = srfc_pkg::ST_CAPACITY;
                end
                if (verdict != srfc_pkg::ST_OK) begin
                    rec_mode = REC_IDLE;
                    due_results.push_back(make_result(verdict, '0, '0, '0, '0, '0));
                end else begin
                    rec_mode     = (it.opcode == srfc_pkg::OP_ENCODE) ? REC_ENC : REC_VAL;
                    rec_magic    = it.magic;
                    rec_version  = it.version;
                    rec_length   = it.body_len;
                    rec_checksum = it.stored_checksum;
                    rec_left     = it.body_len;
                    rec_hash     = srfc_pkg::FNV_BASIS;
                    if (it.body_len == 32'd0) close_record();
                end
            end
            srfc_pkg::OP_BYTE: begin
                if (rec_mode != REC_IDLE) begin
                    rec_hash = fnv_step(rec_hash, it.data_byte);
                    rec_left = rec_left - 32'd1;
                    if (rec_left == 32'd0) close_record();
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [1:0] op, input logic [31:0] mg, input logic [15:0] ver,
                             input logic [15:0] hs, input logic [31:0] ps,
                             input logic [31:0] ck, input logic [7:0] db, input bit counts);
        srfc_pkg::t_in_item it;
        it.opcode          = srfc_pkg::t_opcode'(op);
        it.magic           = mg;
        it.version         = ver;
        it.hdr_len         = hs;
        it.body_len        = ps;
        it.stored_checksum = ck;
        it.data_byte       = db;
        pending_items.push_back(it);
        if (counts) stim_count++;
    endtask

    // payload bytes carry junk in the unused fields; a reserved opcode slips in now and then
    task automatic queue_body(input logic [7:0] body[$]);
        foreach (body[i]) begin
            if ($urandom_range(19) == 0)
                push_item(OPC_RESERVED, $urandom, 16'($urandom), 16'($urandom), $urandom,
                          $urandom, 8'($urandom), 1'b0);
            push_item(srfc_pkg::OP_BYTE, $urandom, 16'($urandom), 16'($urandom), $urandom,
                      $urandom, body[i], 1'b1);
        end
    endtask

    task automatic queue_random_record();
        int unsigned pick;
        int unsigned nb;
        logic [31:0] mg;
        logic [31:0] ps;
        logic [31:0] ck;
        logic [31:0] lim;
        logic [15:0] ver;
        logic [15:0] hs;
        logic [7:0]  body[$];
        pick = $urandom_range(99);
        mg   = cfg_magic;
        ver  = cfg_version;
        hs   = srfc_pkg::HEADER_BYTES;
        lim  = (cfg_capacity < 32'd12) ? cfg_capacity : 32'd12;
        if (pick < 35) begin
            // well-formed validate, mostly with the right checksum
            nb = $urandom_range(lim);
            repeat (nb) body.push_back(8'($urandom));
            ck = ($urandom_range(3) == 0) ? $urandom : body_hash(body);
            push_item(srfc_pkg::OP_VALIDATE, mg, ver, hs, nb, ck, 8'($urandom), 1'b1);
            queue_body(body);
        end else if (pick < 60 || pick >= 90) begin
            mg = $urandom;
            ver = 16'($urandom);
            if ($urandom_range(15) == 0) mg = '0;
            if ($urandom_range(15) == 0) ver = '0;
            nb = (pick >= 90) ? $urandom_range(13, 64) : $urandom_range(12);
            repeat (nb) body.push_back(8'($urandom));
            push_item(srfc_pkg::OP_ENCODE, mg, ver, 16'($urandom), nb, $urandom,
                      8'($urandom), 1'b1);
            if (mg != 32'd0 && ver != 16'd0) queue_body(body);
        end else if (pick < 72) begin
            // one header field wrong
            ps = $urandom_range(lim);
            case ($urandom_range(3))
                0: begin
                    hs = 16'($urandom);
                    if (hs == srfc_pkg::HEADER_BYTES) hs = ~hs;
                end
                1: mg = cfg_magic ^ ($urandom | 32'd1);
                2: ver = cfg_version ^ (16'($urandom) | 16'd1);
                default: begin
                    ps = $urandom;
                    if (cfg_capacity != 32'hFFFF_FFFF && ps <= cfg_capacity)
                        ps = cfg_capacity + 32'd1;
                end
            endcase
            push_item(srfc_pkg::OP_VALIDATE, mg, ver, hs, ps, $urandom, 8'($urandom), 1'b1);
        end else if (pick < 80) begin
            // long record cut short by the next start
            ps = $urandom;
            if (ps < 32'd8) ps = ps + 32'd8;
            repeat ($urandom_range(3)) body.push_back(8'($urandom));
            if ($urandom_range(1) == 0)
                push_item(srfc_pkg::OP_VALIDATE, mg, ver, hs, ps, $urandom, 8'($urandom),
                          1'b1);
            else
                push_item(srfc_pkg::OP_ENCODE, $urandom | 32'd1, 16'($urandom) | 16'd1,
                          16'($urandom), ps, $urandom, 8'($urandom), 1'b1);
            queue_body(body);
        end else begin
            repeat ($urandom_range(1, 3))
                push_item(($urandom_range(1) == 0) ? srfc_pkg::OP_BYTE : OPC_RESERVED,
                          $urandom, 16'($urandom), 16'($urandom), $urandom, $urandom,
                          8'($urandom), 1'b0);
        end
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge i_clk);
        // ignored or abandoned transactions may still sit in the pipe
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input srfc_pkg::t_cfg_index idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            srfc_pkg::CFG_MAGIC:    cfg_magic = data;
            srfc_pkg::CFG_VERSION:  cfg_version = data[15:0];
            srfc_pkg::CFG_CAPACITY: cfg_capacity = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] mg, input logic [15:0] ver,
                             input logic [31:0] cap, input int unsigned budget,
                             input bit hold_mid);
        int unsigned target;
        write_reg(srfc_pkg::CFG_MAGIC, mg);
        write_reg(srfc_pkg::CFG_VERSION, {16'd0, ver});
        write_reg(srfc_pkg::CFG_CAPACITY, cap);
        settings_used++;
        target = stim_count + budget;
        while (stim_count < target) begin
            queue_random_record();
            if (hold_mid && stim_count >= target - budget / 2) begin
                // sender holds off until the block has drained
                settle();
                hold_mid = 1'b0;
            end
        end
        // leave the block idle before the next register writes
        push_item(srfc_pkg::OP_ENCODE, $urandom | 32'd1, 16'($urandom) | 16'd1,
                  16'($urandom), 32'd1, $urandom, 8'($urandom), 1'b1);
        push_item(srfc_pkg::OP_BYTE, $urandom, 16'($urandom), 16'($urandom), $urandom,
                  $urandom, 8'($urandom), 1'b1);
        settle();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                fold_record_item(in_data);
                items_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            fail_count++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_data);
                fail_count++;
            end else begin
                head_result = due_results.pop_front();
                check_field("status", 32'(head_result.status), 32'(o_out_data.status));
                check_field("magic_out", head_result.magic_out, o_out_data.magic_out);
                check_field("version_out", 32'(head_result.version_out),
                            32'(o_out_data.version_out));
                check_field("hdr_len_out", 32'(head_result.hdr_len_out),
                            32'(o_out_data.hdr_len_out));
                check_field("body_len_out", head_result.body_len_out,
                            o_out_data.body_len_out);
                check_field("hash_result", head_result.hash_result, o_out_data.hash_result);
                results_checked++;
            end
        end
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    initial begin
        #(RUN_LIMIT);
        $display("%0t: run limit reached with %0d results outstanding", $time,
                 due_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0] body[$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: every validate is an invalid argument
        push_item(srfc_pkg::OP_ENCODE, 32'd0, 16'd5, srfc_pkg::HEADER_BYTES, 32'd3, '0, '0,
                  1'b1);
        push_item(srfc_pkg::OP_ENCODE, 32'd1, 16'd0, srfc_pkg::HEADER_BYTES, 32'd3, '0, '0,
                  1'b1);
        push_item(srfc_pkg::OP_VALIDATE, 32'd0, 16'd0, srfc_pkg::HEADER_BYTES, 32'd0, '0, '0,
                  1'b1);
        push_item(srfc_pkg::OP_BYTE, '1, '1, '1, '1, '1, 8'hFF, 1'b1);
        push_item(OPC_RESERVED, '1, '1, '1, '1, '1, 8'hFF, 1'b1);
        push_item(srfc_pkg::OP_ENCODE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0, '1, '0, 1'b1);
        push_item(srfc_pkg::OP_ENCODE, 32'd1, 16'd1, 16'd0, 32'd2, '0, '0, 1'b1);
        body = '{8'h00, 8'hFF};
        queue_body(body);
        settle();

        write_reg(srfc_pkg::CFG_MAGIC, 32'hA5C3_0F17);
        write_reg(srfc_pkg::CFG_VERSION, 32'h0000_0102);
        write_reg(srfc_pkg::CFG_CAPACITY, 32'd8);
        settings_used++;
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0102, 16'd15, 32'd2, '0, '0, 1'b1);
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F16, 16'h0102, srfc_pkg::HEADER_BYTES,
                  32'd2, '0, '0, 1'b1);
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0103, srfc_pkg::HEADER_BYTES,
                  32'd2, '0, '0, 1'b1);
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0102, srfc_pkg::HEADER_BYTES,
                  32'd9, '0, '0, 1'b1);
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0102, srfc_pkg::HEADER_BYTES,
                  32'd0, srfc_pkg::FNV_BASIS, '0, 1'b1);
        body = '{8'h61, 8'h80};
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0102, srfc_pkg::HEADER_BYTES,
                  32'd2, body_hash(body), '0, 1'b1);
        queue_body(body);
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0102, srfc_pkg::HEADER_BYTES,
                  32'd1, 32'hDEAD_BEEF, '0, 1'b1);
        push_item(srfc_pkg::OP_BYTE, '0, '0, '0, '0, '0, 8'h5A, 1'b1);
        // start while busy: the open encode is dropped, the empty validate mismatches
        push_item(srfc_pkg::OP_ENCODE, 32'h1234_5678, 16'h0001, srfc_pkg::HEADER_BYTES,
                  32'hFFFF_FFFF, '0, '0, 1'b1);
        push_item(srfc_pkg::OP_BYTE, '0, '0, '0, '0, '0, 8'h01, 1'b1);
        push_item(srfc_pkg::OP_VALIDATE, 32'hA5C3_0F17, 16'h0102, srfc_pkg::HEADER_BYTES,
                  32'd0, 32'd0, '0, 1'b1);
        settle();

        run_phase($urandom | 32'd1, 16'($urandom) | 16'd1, 32'd24, 300, 1'b1);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 300, 1'b0);
        run_phase(32'd1, 16'd1, 32'd0, 250, 1'b0);
        run_phase(32'd0, 16'($urandom) | 16'd1, 32'd12, 250, 1'b0);
        run_phase($urandom | 32'd1, 16'd0, 32'd12, 200, 1'b0);
        idle_pct = 0;
        run_phase($urandom | 32'd1, 16'($urandom) | 16'd1, 32'd16, 450, 1'b0);

        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due_results.size());
            fail_count++;
        end
        $display("Streamed %0d transactions under %0d register settings, %0d results checked",
                 items_taken, settings_used, results_checked);
        $display("(encode, validate with every failure kind, aborted and empty records).");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
